>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> rtl/fpws_pkg.sv
// ----------------------------------------------------------------------------
// fpws_pkg
// Shared types and constants of the frame pacer with statistics.
// ----------------------------------------------------------------------------
`default_nettype none
package fpws_pkg;

   localparam int WINDOW       = 120;
   localparam int DRAIN_FRAMES = 30;
   localparam int REPORT_EVERY = 10;

   localparam int WIN_DEPTH = 128;
   localparam int FILL_W    = 7;
   localparam int DRAIN_W   = 5;
   localparam int REP_W     = $clog2(REPORT_EVERY + 1);

   localparam int QDEPTH = 2;
   localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam int DIV_NW    = 64;
   localparam int DIV_DW    = 48;
   localparam int DIV_STEPS = DIV_NW;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   localparam int PCT_KEEP = 99;
   localparam int PCT_ALL  = 100;
   localparam logic [19:0] US_PER_S = 20'd1000000;

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_PACING = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_TARGET = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_FREQ   = 2'd2;

   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [47:0] now_ticks;
      logic [2:0]  sync_interval;
   } fpws_req_type;

   typedef struct packed {
      logic [47:0] release_ticks;
      logic        measured;
      logic [31:0] frame_ticks;
      logic [31:0] lateness_ticks;
      logic [31:0] low_frame_ticks;
      logic [23:0] low_fps_q8;
      logic [15:0] stutter_pct_q8;
      logic [31:0] frame_count;
      logic        report_due;
      logic [2:0]  sync_interval_out;
   } fpws_rsp_type;

   typedef struct packed {
      logic        pacing_enable;
      logic [9:0]  target_fps;
      logic [39:0] tick_freq;
   } fpws_cfg_type;

   typedef struct packed {
      logic [47:0] release_ticks;
      logic        measured;
      logic [31:0] frame_ticks;
      logic [31:0] lateness_ticks;
      logic [31:0] frame_count;
      logic        report_due;
      logic [2:0]  sync_interval_out;
   } fpws_job_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } fpws_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quotient;
   } fpws_div_rsp_type;

   typedef enum logic [1:0] {F_IDLE, F_CALC, F_DIV, F_FIN} fpws_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_RDOLD, B_UPD, B_WALK, B_MUL, B_FPS, B_FPSW, B_STUT, B_STUTW, B_DONE
   } fpws_back_state_type;

endpackage
`default_nettype wire

>>> rtl/fpws_div.sv
// ----------------------------------------------------------------------------
// fpws_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fpws_div (
   input  logic                      clock,
   input  logic                      reset,
   input  fpws_pkg::fpws_div_req_type div_req,
   output fpws_pkg::fpws_div_rsp_type div_rsp
);
   import fpws_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dv_ff;
   logic [DIV_DW:0]   shifted;
   logic              qbit;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      qbit    = (shifted >= {1'b0, dv_ff});
      rem_in  = qbit ? DIV_DW'(shifted - {1'b0, dv_ff}) : shifted[DIV_DW-1:0];
      quo_in  = {quo_ff[DIV_NW-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dv_ff  <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/fpws_front.sv
// ----------------------------------------------------------------------------
// fpws_front
// Accepts present requests, applies the cap deadline and drain, tags results.
// ----------------------------------------------------------------------------
`default_nettype none
module fpws_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  fpws_pkg::fpws_req_type     req_data,
   output logic                       req_stall,
   input  fpws_pkg::fpws_cfg_type     cfg,
   output fpws_pkg::fpws_div_req_type div_req,
   input  fpws_pkg::fpws_div_rsp_type div_rsp,
   output logic                       q_push,
   output fpws_pkg::fpws_job_type     q_job,
   input  logic                       q_full
);
   import fpws_pkg::*;

   fpws_front_state_type state_ff, state_in;

   logic [47:0]        now_ff;
   logic [2:0]         sync_ff;
   logic [47:0]        last_ff, last_in;
   logic               started_ff, started_in;
   logic [9:0]         seen_ff, seen_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic [31:0]        frames_ff, frames_in;
   logic [REP_W-1:0]   rep_ff, rep_in;

   logic               paced_path;
   logic [48:0]        deadline;
   logic [48:0]        late_diff;
   logic [47:0]        lastv;
   logic [47:0]        rel;
   logic [47:0]        fdiff;
   fpws_job_type       job;

   assign paced_path = (cfg.target_fps == seen_ff) && started_ff && cfg.pacing_enable &&
                       (cfg.target_fps != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !q_full) state_in = F_CALC;
         end
         F_CALC: begin
            state_in = paced_path ? F_DIV : F_IDLE;
         end
         F_DIV: begin
            if (div_rsp.done) state_in = F_FIN;
         end
         F_FIN: begin
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall        = 1'b1;
      q_push           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {24'b0, cfg.tick_freq};
      div_req.divisor  = {38'b0, cfg.target_fps};
      case (state_ff)
         F_IDLE: begin
            req_stall = q_full;
         end
         F_CALC: begin
            div_req.start = paced_path;
            q_push        = !paced_path;
         end
         F_FIN: begin
            q_push = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // pacing decision and result tagging
   always_comb begin
      last_in    = last_ff;
      started_in = started_ff;
      seen_in    = seen_ff;
      drain_in   = drain_ff;
      frames_in  = frames_ff;
      rep_in     = rep_ff;
      job        = '0;
      job.release_ticks = now_ff;
      job.frame_count   = frames_ff;
      deadline  = {1'b0, last_ff} + {9'b0, div_rsp.quotient[39:0]};
      late_diff = {1'b0, now_ff} - deadline;
      lastv     = last_ff;
      rel       = now_ff;
      fdiff     = '0;
      if (cfg.target_fps != seen_ff) begin
         // cap change: resync, and a cap of zero starts the drain
         seen_in    = cfg.target_fps;
         last_in    = now_ff;
         started_in = 1'b1;
         if (cfg.target_fps == '0) drain_in = DRAIN_W'(DRAIN_FRAMES);
      end else if (!started_ff) begin
         started_in = 1'b1;
         last_in    = now_ff;
      end else begin
         if (cfg.pacing_enable && (cfg.target_fps != '0)) begin
            if ({1'b0, now_ff} > deadline) begin
               rel = now_ff;
               job.lateness_ticks = (|late_diff[47:32]) ? 32'hFFFF_FFFF : late_diff[31:0];
            end else begin
               rel = deadline[48] ? M48 : deadline[47:0];
            end
         end else if (drain_ff != '0) begin
            drain_in = drain_ff - 1'b1;
            lastv    = now_ff;
         end
         fdiff = rel - lastv;
         if (rel >= lastv) begin
            job.frame_ticks = (|fdiff[47:32]) ? 32'hFFFF_FFFF : fdiff[31:0];
         end
         last_in   = rel;
         frames_in = frames_ff + 1'b1;
         if (frames_in == '0) begin
            rep_in = '0;
         end else if (rep_ff == REP_W'(REPORT_EVERY - 1)) begin
            rep_in = '0;
         end else begin
            rep_in = rep_ff + 1'b1;
         end
         job.release_ticks = rel;
         job.measured      = 1'b1;
         job.frame_count   = frames_in;
         job.report_due    = (rep_in == '0);
      end
      job.sync_interval_out = (drain_in != '0) ? 3'd0 : sync_ff;
   end

   assign q_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         last_ff    <= '0;
         started_ff <= 1'b0;
         seen_ff    <= '0;
         drain_ff   <= '0;
         frames_ff  <= '0;
         rep_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (q_push) begin
            last_ff    <= last_in;
            started_ff <= started_in;
            seen_ff    <= seen_in;
            drain_ff   <= drain_in;
            frames_ff  <= frames_in;
            rep_ff     <= rep_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid && !q_full) begin
         now_ff  <= req_data.now_ticks;
         sync_ff <= req_data.sync_interval;
      end
   end

endmodule
`default_nettype wire

>>> rtl/fpws_queue.sv
// ----------------------------------------------------------------------------
// fpws_queue
// Short queue of tagged results between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module fpws_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fpws_pkg::fpws_job_type push_job,
   input  logic                   pop,
   output logic                   q_valid,
   output logic                   q_full,
   output fpws_pkg::fpws_job_type head_job
);
   import fpws_pkg::*;

   fpws_job_type   slot_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QCW-1:0] cnt_ff;
   logic           do_push, do_pop;

   assign q_valid  = (cnt_ff != '0);
   assign q_full   = (cnt_ff == QCW'(QDEPTH));
   assign head_job = slot_ff[rp_ff];
   assign do_push  = push && !q_full;
   assign do_pop   = pop && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= (wp_ff == QAW'(QDEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (do_pop)  rp_ff <= (rp_ff == QAW'(QDEPTH - 1)) ? '0 : rp_ff + 1'b1;
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= push_job;
   end

endmodule
`default_nettype wire

>>> rtl/fpws_back.sv
// ----------------------------------------------------------------------------
// fpws_back
// Frame-time window, 1% low and stutter statistics, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module fpws_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  fpws_pkg::fpws_job_type q_job,
   output logic                   q_pop,
   input  logic [39:0]            tick_freq,
   output logic                   rsp_valid,
   output fpws_pkg::fpws_rsp_type rsp_data,
   input  logic                   rsp_stall
);
   import fpws_pkg::*;

   fpws_back_state_type state_ff, state_in;

   logic [31:0]       win_mem [WIN_DEPTH];
   logic [31:0]       rd_ff;
   logic [FILL_W-1:0] rd_addr;
   logic              mem_we;

   fpws_job_type      job_ff;
   logic [FILL_W-1:0] fill_ff, head_ff, wc_ff;
   logic [38:0]       sum_ff, sum_in;
   logic              win_full;
   logic [31:0]       top1_ff, top2_ff;
   logic [45:0]       dev_ff;
   logic [38:0]       dn, ad;
   logic [31:0]       lowt_sel, lowt_ff;
   logic [51:0]       lowt_us;
   logic [58:0]       sum_us;
   logic [46:0]       n_freq;
   logic              fps_ok_ff, stut_ok_ff;
   logic [45:0]       ns_ff;
   logic [52:0]       dev100;
   logic [60:0]       devx_ff;
   logic [23:0]       fps_ff;
   logic [15:0]       stut_ff;
   logic              ov_ff, load_out;
   fpws_rsp_type      odata_ff;

   fpws_div_req_type  div_req;
   fpws_div_rsp_type  div_rsp;

   fpws_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign win_full = (fill_ff == FILL_W'(WINDOW));
   assign sum_in   = sum_ff - (win_full ? {7'b0, rd_ff} : 39'b0) + {7'b0, job_ff.frame_ticks};
   assign dn       = {7'b0, rd_ff} * {32'b0, fill_ff};
   assign ad       = (dn > sum_ff) ? (dn - sum_ff) : (sum_ff - dn);
   assign lowt_sel = ((14'(fill_ff) * 14'(PCT_KEEP)) >=
                      ((14'(fill_ff) - 14'd1) * 14'(PCT_ALL))) ? top1_ff : top2_ff;
   assign lowt_us  = {20'b0, lowt_sel} * {32'b0, US_PER_S};
   assign sum_us   = {20'b0, sum_ff} * {39'b0, US_PER_S};
   assign n_freq   = {40'b0, fill_ff} * {7'b0, tick_freq};
   assign dev100   = {1'b0, dev_ff, 6'b0} + {2'b0, dev_ff, 5'b0} + {5'b0, dev_ff, 2'b0};
   assign load_out = (state_ff == B_DONE) && (!ov_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (q_valid) state_in = q_job.measured ? B_RDOLD : B_DONE;
         B_RDOLD: state_in = B_UPD;
         B_UPD:   state_in = B_WALK;
         B_WALK:  if (wc_ff == fill_ff) state_in = B_MUL;
         B_MUL:   state_in = B_FPS;
         B_FPS:   state_in = fps_ok_ff ? B_FPSW : B_STUT;
         B_FPSW:  if (div_rsp.done) state_in = B_STUT;
         B_STUT:  state_in = stut_ok_ff ? B_STUTW : B_DONE;
         B_STUTW: if (div_rsp.done) state_in = B_DONE;
         B_DONE:  if (load_out) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop            = 1'b0;
      mem_we           = 1'b0;
      rd_addr          = wc_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {16'b0, tick_freq, 8'b0};
      div_req.divisor  = {16'b0, lowt_ff};
      case (state_ff)
         B_IDLE:  q_pop = q_valid;
         B_RDOLD: rd_addr = head_ff;
         B_UPD:   mem_we = 1'b1;
         B_FPS:   div_req.start = fps_ok_ff;
         B_STUT: begin
            div_req.start    = stut_ok_ff;
            div_req.dividend = {3'b0, devx_ff};
            div_req.divisor  = {2'b0, ns_ff};
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) win_mem[head_ff] <= job_ff.frame_ticks;
      rd_ff <= win_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
         sum_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_UPD) begin
            sum_ff  <= sum_in;
            head_ff <= (head_ff == FILL_W'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
            if (!win_full) fill_ff <= fill_ff + 1'b1;
         end
         if (load_out)              ov_ff <= 1'b1;
         else if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               job_ff  <= q_job;
               lowt_ff <= '0;
               fps_ff  <= '0;
               stut_ff <= '0;
            end
         end
         B_UPD: begin
            wc_ff   <= '0;
            top1_ff <= '0;
            top2_ff <= '0;
            dev_ff  <= '0;
         end
         B_WALK: begin
            // read data is registered, so it belongs to the previous cycle's address
            if (wc_ff != '0) begin
               if (rd_ff >= top1_ff) begin
                  top2_ff <= top1_ff;
                  top1_ff <= rd_ff;
               end else if (rd_ff > top2_ff) begin
                  top2_ff <= rd_ff;
               end
               dev_ff <= dev_ff + {7'b0, ad};
            end
            wc_ff <= wc_ff + 1'b1;
         end
         B_MUL: begin
            lowt_ff    <= lowt_sel;
            fps_ok_ff  <= (lowt_us > {12'b0, tick_freq});
            stut_ok_ff <= (sum_us > {12'b0, n_freq});
            ns_ff      <= {39'b0, fill_ff} * {7'b0, sum_ff};
            devx_ff    <= {dev100, 8'b0};
         end
         B_FPSW: begin
            if (div_rsp.done)
               fps_ff <= (|div_rsp.quotient[63:24]) ? 24'hFF_FFFF : div_rsp.quotient[23:0];
         end
         B_STUTW: begin
            if (div_rsp.done)
               stut_ff <= (|div_rsp.quotient[63:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
         end
         B_DONE: begin
            if (load_out) begin
               odata_ff.release_ticks     <= job_ff.release_ticks;
               odata_ff.measured          <= job_ff.measured;
               odata_ff.frame_ticks       <= job_ff.frame_ticks;
               odata_ff.lateness_ticks    <= job_ff.lateness_ticks;
               odata_ff.low_frame_ticks   <= lowt_ff;
               odata_ff.low_fps_q8        <= fps_ff;
               odata_ff.stutter_pct_q8    <= stut_ff;
               odata_ff.frame_count       <= job_ff.frame_count;
               odata_ff.report_due        <= job_ff.report_due;
               odata_ff.sync_interval_out <= job_ff.sync_interval_out;
            end
         end
         default: begin
            wc_ff <= wc_ff;
         end
      endcase
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = odata_ff;

endmodule
`default_nettype wire

>>> rtl/frame_pacer_with_stats_unit.sv
// ----------------------------------------------------------------------------
// frame_pacer_with_stats_unit
// Present pacer with frame-time window statistics.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one present request (timestamp, vsync interval); a transfer
//   happens when req_valid is high and req_stall low. Every request gives
//   exactly one transfer on rsp_*: release time, frame and lateness ticks,
//   1% low in ticks and Q8 fps, stutter in Q8 percent and the frame count.
//   csr_* writes pacing_enable (0), target_fps (1) and tick_freq (2) with
//   no wait; write only while the block is idle.
//   The front takes one request at a time and stalls the next until its
//   result is pushed; the cap deadline needs tick_freq / target_fps from
//   its 64-step divider. The back walks the n-entry window once (one memory
//   read per cycle) and runs up to two 64-step divides; a skipped divide
//   leaves its statistic zero, and a resync frame skips walk and divides.
//   A two-entry queue parts front and back; the output register lets the
//   back finish the next frame while a result is stalled, then it waits.
//   Synchronous reset restores the register defaults, empties the window
//   and clears all pacing state; the window memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module frame_pacer_with_stats_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  fpws_pkg::fpws_req_type              req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output fpws_pkg::fpws_rsp_type              rsp_data,
   input  logic                                rsp_stall,
   input  logic                                csr_we,
   input  logic [fpws_pkg::CSR_IW-1:0]         csr_index,
   input  logic [39:0]                         csr_wdata
);
   import fpws_pkg::*;

   fpws_cfg_type     cfg_ff;
   fpws_div_req_type div_req;
   fpws_div_rsp_type div_rsp;
   logic             q_push, q_pop, q_valid, q_full;
   fpws_job_type     q_job, q_head;
   logic             req_xfer, unmeasured_rsp, unmeasured_clean;

   // configuration registers; writes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pacing_enable <= 1'b1;
         cfg_ff.target_fps    <= '0;
         cfg_ff.tick_freq     <= 40'd10000000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PACING: cfg_ff.pacing_enable <= csr_wdata[0];
            CSR_TARGET: cfg_ff.target_fps    <= csr_wdata[9:0];
            CSR_FREQ:   cfg_ff.tick_freq     <= csr_wdata;
            default:    cfg_ff <= cfg_ff;
         endcase
      end
   end

   // front: accept, pace, tag
   fpws_div u_front_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fpws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .cfg       (cfg_ff),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .q_push    (q_push),
      .q_job     (q_job),
      .q_full    (q_full)
   );

   // hold tagged frames between the two halves
   fpws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .head_job (q_head)
   );

   // back: window statistics and result transfer
   fpws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_head),
      .q_pop     (q_pop),
      .tick_freq (cfg_ff.tick_freq),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign req_xfer         = req_valid && !req_stall;
   assign unmeasured_rsp   = rsp_valid && !rsp_data.measured;
   assign unmeasured_clean = (rsp_data.frame_ticks == 32'd0) &&
                             (rsp_data.stutter_pct_q8 == 16'd0) && !rsp_data.report_due;

   `ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_full, "queue push while full")
   `ASSERT_CLK(a_accept_blocks, clock, reset, req_xfer |=> req_stall, "second accept too soon")
   `ASSERT_CLK(a_unmeasured_zero, clock, reset, unmeasured_rsp |-> unmeasured_clean, "resync stats")

endmodule
`default_nettype wire
